/* rtl/core/psde_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psde_pkg
// Shared constants, register map and sample expansion for the packed sample
// depth expander.
// ----------------------------------------------------------------------------
package psde_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IdxW    = 3;   // sample index inside one byte
  localparam int unsigned RowW    = 16;
  localparam int unsigned CountW  = 18;  // holds 65535 * 3
  localparam int unsigned PaddrW  = 5;
  localparam int unsigned PdataW  = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] RegDepthCode  = 3'd0;
  localparam logic [2:0] RegComponents = 3'd1;
  localparam logic [2:0] RegRowPixels  = 3'd2;
  localparam logic [2:0] RegIndexed    = 3'd3;
  localparam logic [2:0] RegInvert     = 3'd4;

  // depth codes
  localparam logic [1:0] Depth1 = 2'd0;
  localparam logic [1:0] Depth2 = 2'd1;
  localparam logic [1:0] Depth4 = 2'd2;
  localparam logic [1:0] Depth8 = 2'd3;

  typedef struct packed {
    logic [1:0]      depth_code;
    logic [1:0]      components;
    logic [RowW-1:0] row_pixels;
    logic            indexed_mode;
    logic            invert_levels;
  } cfg_t;

  // index of the last sample a byte can yield at this depth
  function automatic logic [IdxW-1:0] last_index(input logic [1:0] depth);
    return 3'(3'd7 >> depth);
  endfunction

  // row length, a zero product counts as one sample
  function automatic logic [CountW-1:0] row_length(input cfg_t cfg);
    logic [CountW-1:0] rp;
    logic [CountW-1:0] n;
    rp = CountW'(cfg.row_pixels);
    case (cfg.components)
      2'd0:    n = '0;
      2'd1:    n = rp;
      2'd2:    n = rp << 1;
      default: n = (rp << 1) + rp;
    endcase
    return (n == '0) ? CountW'(1) : n;
  endfunction

  // pick sample idx (msb first) and scale it to 0..255, inverted when set, or pass the index
  function automatic logic [ByteW-1:0] expand(input logic [ByteW-1:0] src,
                                              input logic [IdxW-1:0]  idx,
                                              input cfg_t             cfg);
    logic [ByteW-1:0] sh;
    logic [ByteW-1:0] v;
    sh = src << (3'(idx << cfg.depth_code));
    case (cfg.depth_code)
      Depth1:  v = cfg.indexed_mode ? {7'd0, sh[7]}    : {8{sh[7]}};
      Depth2:  v = cfg.indexed_mode ? {6'd0, sh[7:6]}  : {4{sh[7:6]}};
      Depth4:  v = cfg.indexed_mode ? {4'd0, sh[7:4]}  : {2{sh[7:4]}};
      default: v = sh;
    endcase
    if (!cfg.indexed_mode && cfg.invert_levels) begin
      v = ~v;
    end
    return v;
  endfunction

endpackage

/* rtl/core/packed_sample_depth_expander_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_sample_depth_expander_unit
// Unpacks raw sample bytes msb first into 8-bit samples of 1, 2, 4 or 8 bits,
// scales or passes them, and flags row ends.
// ----------------------------------------------------------------------------
// each byte is held in byte_q and its samples are registered in the output register
// throughput: one sample per cycle while the output is not stalled; a byte yields
//   8 / depth samples, fewer when a row ends inside it; the next byte is taken as
//   the current one's last sample moves into the output register
// reset: asynchronous, active low; config and control registers go to their
//   defaults, the row counter to zero so the next byte starts a row
module packed_sample_depth_expander_unit
  import psde_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] source_byte
  // output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [7:0] sample_value
  output logic              m_axis_tlast,   // row_end
  output logic              m_axis_tuser    // [0] last
);

  cfg_t cfg_q;

  logic [ByteW-1:0]  byte_q;
  logic              busy_q, busy_d;
  logic [IdxW-1:0]   idx_q,  idx_d;
  logic [CountW-1:0] left_q, left_d;

  logic              out_valid_q;
  logic [ByteW-1:0]  sample_q;
  logic              row_end_q;
  logic              last_q;

  logic              in_xfer;
  logic              advance;
  logic [CountW-1:0] cur_left;
  logic              row_end_d;
  logic              last_d;
  logic              cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_code    <= Depth8;
      cfg_q.components    <= 2'd1;
      cfg_q.row_pixels    <= RowW'(1);
      cfg_q.indexed_mode  <= 1'b0;
      cfg_q.invert_levels <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        RegDepthCode:  cfg_q.depth_code    <= pwdata[1:0];
        RegComponents: cfg_q.components    <= pwdata[1:0];
        RegRowPixels:  cfg_q.row_pixels    <= pwdata[RowW-1:0];
        RegIndexed:    cfg_q.indexed_mode  <= pwdata[0];
        RegInvert:     cfg_q.invert_levels <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      RegDepthCode:  prdata = PdataW'(cfg_q.depth_code);
      RegComponents: prdata = PdataW'(cfg_q.components);
      RegRowPixels:  prdata = PdataW'(cfg_q.row_pixels);
      RegIndexed:    prdata = PdataW'(cfg_q.indexed_mode);
      RegInvert:     prdata = PdataW'(cfg_q.invert_levels);
      default:       prdata = '0;
    endcase
  end

  // sample step on the held byte
  assign advance   = busy_q && (!out_valid_q || m_axis_tready);
  assign cur_left  = (left_q == '0) ? row_length(cfg_q) : left_q;
  assign left_d    = cur_left - CountW'(1);
  assign row_end_d = (left_d == '0);
  assign last_d    = row_end_d || (idx_q == last_index(cfg_q.depth_code));

  assign s_axis_tready = !busy_q || (advance && last_d);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // a new byte transfer wins over the end of the current one
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (advance) begin
      idx_d = idx_q + IdxW'(1);
      if (last_d) begin
        busy_d = 1'b0;
      end
    end
    if (in_xfer) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      left_q <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      if (advance) begin
        left_q <= left_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q <= s_axis_tdata;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sample_q  <= expand(byte_q, idx_q, cfg_q);
      row_end_q <= row_end_d;
      last_q    <= last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = sample_q;
  assign m_axis_tlast  = row_end_q;
  assign m_axis_tuser  = last_q;

`ifndef SYNTHESIS
  a_row_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && row_end_q) |-> last_q)
    else $error("row end without byte end");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= last_index(cfg_q.depth_code)))
    else $error("sample index past end of byte");

  a_take_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (busy_q && idx_q == '0))
    else $error("byte transfer did not load the unpacker");

  a_no_take_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !(advance && last_d)) |-> !s_axis_tready)
    else $error("ready while byte still unpacking");
`endif

endmodule
